[rtl/core/wls_pkg.sv]
// Shared types and constants for the windowed latency statistics block.
// No dependencies.
package wls_pkg;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int OUT_TIME_W = 24;
  localparam int OUT_CNT_W  = 10;
  localparam int RATE_W     = 17;
  localparam int CNT_W      = 32;

  // datapath commands from the controller
  typedef struct packed {
    logic load;       // latch query inputs, reset accumulators
    logic scan_step;  // accumulate one sample, count rank candidates
    logic div_start;  // launch the dividers
    logic div_step;   // one quotient bit per divider
    logic write;      // write a sample at the write slot
    logic clear;      // empty the window
    logic sel_next;   // take the next percentile candidate
  } wls_cmd_t;

  typedef struct packed {
    logic scan_last;  // current scan index is the last sample
    logic div_done;   // all quotient bits produced
    logic sel_done;   // percentile found
    logic empty;      // window holds no samples
  } wls_sts_t;

endpackage

[rtl/core/wls_datapath.sv]
// Datapath: sample ring, scan accumulators, rank selection and serial dividers.
// Depends on wls_pkg.
module wls_datapath #(
  parameter int WINDOW    = 1000,
  parameter int TIME_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wls_pkg::wls_cmd_t        cmd,
  output wls_pkg::wls_sts_t        sts,
  input  logic [23:0]              in_time,
  input  logic [31:0]              in_req,
  input  logic [31:0]              in_resp,
  input  logic [31:0]              in_tmo,
  output logic [9:0]               sample_count,
  output logic [23:0]              mean_time,
  output logic [23:0]              min_time,
  output logic [23:0]              max_time,
  output logic [23:0]              p95_time,
  output logic [16:0]              success_rate,
  output logic [16:0]              timeout_rate
);
  import wls_pkg::*;

  localparam int IW   = $clog2(WINDOW);
  localparam int NW   = $clog2(WINDOW + 1);
  localparam int SW   = TIME_BITS + NW;
  localparam int DIVN = (SW > 49) ? SW : 49;   // quotient steps
  localparam int DW   = DIVN;

  logic [TIME_BITS-1:0] ring [WINDOW];
  logic [IW-1:0]  wslot_r;
  logic [NW-1:0]  fill_r;
  logic [IW-1:0]  idx_r;
  logic [TIME_BITS-1:0] rd_r;
  logic           rd_vld_r;
  logic [SW-1:0]  sum_r;
  logic [TIME_BITS-1:0] mn_r, mx_r, cand_r, p95_r, nxt_r;
  logic [NW-1:0]  below_r, equal_r, rank_r;
  logic           sel_done_r;
  logic [31:0]    req_r;
  // serial dividers: remainder/quotient shift registers
  logic [DW-1:0]  num_m_r, num_s_r, num_t_r;
  logic [NW:0]    rem_m_r;
  logic [32:0]    rem_s_r, rem_t_r;
  logic [DW-1:0]  q_m_r, q_s_r, q_t_r;
  logic [6:0]     dcnt_r;

  // rank = ceil(n*95/100) = n - floor(n/20); floor(q/5) by reciprocal multiply
  logic [NW-1:0]    quarter;
  logic [NW+12-1:0] fifth_prod;
  logic [NW-1:0]    rank_c;
  assign quarter    = fill_r >> 2;
  assign fifth_prod = (NW+12)'(quarter) * 12'd3277;
  assign rank_c     = fill_r - NW'(fifth_prod >> 14);

  always_ff @(posedge clk) begin
    if (cmd.write) ring[wslot_r] <= in_time[TIME_BITS-1:0];
    rd_r <= ring[idx_r];
  end

  logic [TIME_BITS-1:0] v;
  assign v = rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r <= '0; fill_r <= '0; rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        wslot_r <= '0; fill_r <= '0;
      end else if (cmd.write) begin
        wslot_r <= (wslot_r == IW'(WINDOW-1)) ? '0 : wslot_r + 1'b1;
        if (fill_r != NW'(WINDOW)) fill_r <= fill_r + 1'b1;
      end
      rd_vld_r <= cmd.scan_step;
    end
  end

  assign sts.scan_last = (NW'(idx_r) == fill_r - 1'b1);
  assign sts.empty     = (fill_r == '0);
  assign sts.div_done  = (dcnt_r == '0);
  assign sts.sel_done  = sel_done_r;

  // scan: idx walks 0..n-1; each read arrives in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.sel_next) begin
      idx_r <= '0;
      sum_r <= '0; below_r <= '0; equal_r <= '0;
      mn_r <= '1; mx_r <= '0;
      if (cmd.load) begin
        req_r  <= in_req;
        rank_r <= rank_c;
        cand_r <= '0;
        sel_done_r <= 1'b0;
      end else begin
        // decide on the previous candidate: done if below<rank<=below+equal
        if (below_r < rank_r && NW'(below_r + equal_r) >= rank_r) begin
          sel_done_r <= 1'b1; p95_r <= cand_r;
        end else if (NW'(below_r + equal_r) < rank_r) begin
          cand_r <= cand_r + 1'b1 + (nxt_r - cand_r - 1'b1);
        end
      end
    end else if (cmd.scan_step && !sts.scan_last) begin
      idx_r <= idx_r + 1'b1;
    end
    if (rd_vld_r) begin
      sum_r <= sum_r + SW'(v);
      if (v < mn_r) mn_r <= v;
      if (v > mx_r) mx_r <= v;
      if (v < cand_r) below_r <= below_r + 1'b1;
      if (v == cand_r) equal_r <= equal_r + 1'b1;
    end
  end

  // smallest sample above the candidate, for skipping ahead
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.sel_next) nxt_r <= '1;
    else if (rd_vld_r && v > cand_r && v < nxt_r) nxt_r <= v;
  end

  // restoring dividers, one quotient bit per step each
  logic [NW:0]  rm_sh;
  logic [32:0]  rs_sh, rt_sh;
  assign rm_sh = {rem_m_r[NW-1:0], num_m_r[DW-1]};
  assign rs_sh = {rem_s_r[31:0], num_s_r[DW-1]};
  assign rt_sh = {rem_t_r[31:0], num_t_r[DW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) dcnt_r <= '0;
    else if (cmd.div_start) dcnt_r <= 7'(DIVN);
    else if (cmd.div_step && dcnt_r != '0) dcnt_r <= dcnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_s_r <= DW'({in_resp, 16'h0});
      num_t_r <= DW'({in_tmo, 16'h0});
    end else if (cmd.div_start) begin
      num_m_r <= DW'(sum_r);
      rem_m_r <= '0; rem_s_r <= '0; rem_t_r <= '0;
      q_m_r <= '0; q_s_r <= '0; q_t_r <= '0;
    end else if (cmd.div_step && dcnt_r != '0) begin
      num_m_r <= num_m_r << 1;
      num_s_r <= num_s_r << 1;
      num_t_r <= num_t_r << 1;
      if (rm_sh >= {1'b0, fill_r}) begin
        rem_m_r <= rm_sh - {1'b0, fill_r}; q_m_r <= {q_m_r[DW-2:0], 1'b1};
      end else begin
        rem_m_r <= rm_sh; q_m_r <= {q_m_r[DW-2:0], 1'b0};
      end
      if (rs_sh >= {1'b0, req_r}) begin
        rem_s_r <= rs_sh - {1'b0, req_r}; q_s_r <= {q_s_r[DW-2:0], 1'b1};
      end else begin
        rem_s_r <= rs_sh; q_s_r <= {q_s_r[DW-2:0], 1'b0};
      end
      if (rt_sh >= {1'b0, req_r}) begin
        rem_t_r <= rt_sh - {1'b0, req_r}; q_t_r <= {q_t_r[DW-2:0], 1'b1};
      end else begin
        rem_t_r <= rt_sh; q_t_r <= {q_t_r[DW-2:0], 1'b0};
      end
    end
  end

  function automatic logic [16:0] sat_rate(input logic [DW-1:0] q, input logic zero);
    if (zero) sat_rate = '0;
    else if (q > DW'(65536)) sat_rate = 17'h10000;
    else sat_rate = q[16:0];
  endfunction

  assign sample_count = OUT_CNT_W'(fill_r);
  assign mean_time    = sts.empty ? '0 : OUT_TIME_W'(q_m_r[TIME_BITS-1:0]);
  assign min_time     = sts.empty ? '0 : OUT_TIME_W'(mn_r);
  assign max_time     = sts.empty ? '0 : OUT_TIME_W'(mx_r);
  assign p95_time     = sts.empty ? '0 : OUT_TIME_W'(p95_r);
  assign success_rate = sat_rate(q_s_r, req_r == '0);
  assign timeout_rate = sat_rate(q_t_r, req_r == '0);

endmodule

[rtl/core/wls_ctrl.sv]
// Controller state machine sequencing scans, rank selection and division.
// Depends on wls_pkg.
module wls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [1:0]         in_cmd,
  input  logic               out_free,
  output logic               busy,
  output logic               res_load,
  output wls_pkg::wls_cmd_t  cmd,
  input  wls_pkg::wls_sts_t  sts
);
  import wls_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       first_r, first_nxt;

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd       = '0;
    res_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_RECORD: cmd.write = 1'b1;
            CMD_CLEAR:  cmd.clear = 1'b1;
            CMD_QUERY: begin
              cmd.load  = 1'b1;
              first_nxt = 1'b1;
              state_nxt = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.empty) begin
          state_nxt = S_DIV; cmd.div_start = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_nxt = S_TAIL;
        end
      end
      S_TAIL: state_nxt = S_SEL;  // let the last read settle
      S_SEL: begin
        if (first_r) begin
          // first pass done: start the dividers, the mean one on its sum
          cmd.div_start = 1'b1;
          first_nxt = 1'b0;
          state_nxt = S_DIV;
        end else if (sts.sel_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd.sel_next = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_step = 1'b0;
          if (sts.empty) state_nxt = S_OUT;
          else begin
            cmd.sel_next = 1'b1; state_nxt = S_SCAN;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          res_load = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; first_r <= 1'b0;
    end else begin
      state_r <= state_nxt; first_r <= first_nxt;
    end
  end
endmodule

[rtl/core/windowed_latency_statistics.sv]
// Top level of the windowed latency statistics block.
// Depends on wls_pkg, wls_ctrl and wls_datapath.
//
// Usage:
//   Input beats on in_* carry a command: record (store one sample in the
//   ring, dropping the oldest once WINDOW samples are held), query, or
//   clear (empty the window). Command code 3 is dropped.
//   Only a query yields a result beat on out_*: count, truncated mean,
//   min, max, nearest-rank 95th percentile and two Q1.16 rates.
// Sequencing:
//   Record and clear are accepted back to back, one per cycle, while no
//   query is in progress. A query walks the ring once (the single memory
//   read port sets one sample per cycle), runs the three restoring
//   dividers (49 steps), then walks the ring once more for each percentile
//   candidate tried: zero, then each distinct sample upward.
//   An empty window skips the walks. in_tready stays low during a query.
// Reset:
//   Synchronous, active low: window emptied, write slot 0, output empty.
//   Ring contents are not cleared; they are only read once written.
// Stall:
//   The result waits in an output register while records and clears are
//   still accepted; a finished query holds until the register frees up.
module windowed_latency_statistics #(
  parameter int WINDOW    = 1000,
  parameter int TIME_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] cmd, [25:2] response_time, [57:26] request_count,
  // [89:58] response_count, [121:90] timeout_count, [127:122] zero
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [9:0] sample_count, [33:10] mean_time, [57:34] min_time,
  // [81:58] max_time, [105:82] p95_time, [122:106] success_rate,
  // [139:123] timeout_rate, [143:140] zero
  output logic [143:0] out_tdata
);
  import wls_pkg::*;

  wls_cmd_t cmd;
  wls_sts_t sts;
  logic busy, res_load, in_fire, out_free;
  logic [9:0]  sc;
  logic [23:0] mt, mn, mx, p9;
  logic [16:0] sr, tr;
  logic        ovld_r;
  logic [139:0] odata_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovld_r || out_tready;

  wls_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_cmd(in_tdata[1:0]), .out_free,
    .busy, .res_load, .cmd, .sts
  );

  wls_datapath #(.WINDOW(WINDOW), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_time(in_tdata[25:2]), .in_req(in_tdata[57:26]),
    .in_resp(in_tdata[89:58]), .in_tmo(in_tdata[121:90]),
    .sample_count(sc), .mean_time(mt), .min_time(mn), .max_time(mx),
    .p95_time(p9), .success_rate(sr), .timeout_rate(tr)
  );

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (res_load) ovld_r <= 1'b1;
    else if (out_tready) ovld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) odata_r <= {tr, sr, p9, mx, mn, mt, sc};
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {4'b0, odata_r};
endmodule

[rtl/core/wls_checker.sv]
// Port-level checker for windowed_latency_statistics, bound to the top level.
// No dependencies.
module wls_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result without a query in progress");
  a_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[122:106] <= 17'h10000 && out_tdata[139:123] <= 17'h10000)
    else $error("rate above one");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9:0] == 10'd0 |-> out_tdata[105:10] == '0)
    else $error("empty window gave nonzero stats");
endmodule

bind windowed_latency_statistics wls_checker u_wls_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
